@@ hw/rtl/qmn_pkg.sv @@
// shared types, widths and sign tables for the quaternion multiply/normalize block
// depends on nothing
package qmn_pkg;

  localparam int IW          = 32;
  localparam int PW          = 64;
  localparam int CW          = 66;
  localparam int VW          = 31;
  localparam int SQW         = 62;
  localparam int SW          = 63;
  localparam int SRCW        = 64;
  localparam int RTW         = 32;
  localparam int RMW         = 34;
  localparam int DW          = 33;
  localparam int QW          = 31;
  localparam int OW          = 32;
  localparam int NORM_STAGES = 7;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;

  localparam logic [OW-1:0] Q_ONE = 32'h4000_0000;

  typedef struct packed {
    logic signed [IW-1:0] left_w;
    logic signed [IW-1:0] left_x;
    logic signed [IW-1:0] left_y;
    logic signed [IW-1:0] left_z;
    logic signed [IW-1:0] right_w;
    logic signed [IW-1:0] right_x;
    logic signed [IW-1:0] right_y;
    logic signed [IW-1:0] right_z;
  } qmn_in_t;

  typedef struct packed {
    logic signed [OW-1:0] prod_w;
    logic signed [OW-1:0] prod_x;
    logic signed [OW-1:0] prod_y;
    logic signed [OW-1:0] prod_z;
    logic                 zero_fallback;
  } qmn_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [3:0][CW-1:0]   comp;
  } qmn_norm_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [3:0][VW-1:0]   vec;
    logic [RMW-1:0]       rem;
    logic [RTW-1:0]       root;
    logic [SRCW-1:0]      src;
  } qmn_sqrt_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [3:0]           neg;
    logic [DW-1:0]        den;
    logic [3:0][RTW-1:0]  rem;
    logic [3:0][QW-1:0]   num;
    logic [3:0][QW-1:0]   quot;
  } qmn_div_t;

  // hamilton product: term j of component i is a[j] * b[i ^ j]
  function automatic logic neg_term(input logic [1:0] i, input logic [1:0] j);
    logic r;
    r = 1'b0;
    case (i)
      2'd0:    r = (j != 2'd0);
      2'd1:    r = (j == 2'd3);
      2'd2:    r = (j == 2'd1);
      default: r = (j == 2'd2);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/qmn_prod.sv @@
// exact hamilton product: sixteen registered products, then signed sums
// depends on qmn_pkg
module qmn_prod import qmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  qmn_in_t   in_data,
  output qmn_norm_t cells_out
);

  logic signed [IW-1:0] a [4];
  logic signed [IW-1:0] b [4];
  logic signed [PW-1:0] prod_r [4][4];
  logic signed [CW-1:0] comp_r [4];
  logic signed [CW-1:0] comp_nxt [4];
  logic                 valid1_r;
  logic                 valid2_r;

  assign a[0] = in_data.left_w;
  assign a[1] = in_data.left_x;
  assign a[2] = in_data.left_y;
  assign a[3] = in_data.left_z;
  assign b[0] = in_data.right_w;
  assign b[1] = in_data.right_x;
  assign b[2] = in_data.right_y;
  assign b[3] = in_data.right_z;

  for (genvar gi = 0; gi < 4; gi++) begin : g_row
    for (genvar gj = 0; gj < 4; gj++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[gi][gj] <= a[gj] * b[gi ^ gj];
        end
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] term;
    for (int i = 0; i < 4; i++) begin
      comp_nxt[i] = '0;
      for (int j = 0; j < 4; j++) begin
        term = {{(CW-PW){prod_r[i][j][PW-1]}}, prod_r[i][j]};
        if (neg_term(2'(i), 2'(j))) begin
          comp_nxt[i] = comp_nxt[i] - term;
        end else begin
          comp_nxt[i] = comp_nxt[i] + term;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        comp_r[i] <= comp_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_comb begin
    cells_out.valid = valid2_r;
    cells_out.zero  = (comp_r[0] == '0) && (comp_r[1] == '0) &&
                      (comp_r[2] == '0) && (comp_r[3] == '0);
    for (int i = 0; i < 4; i++) begin
      cells_out.comp[i] = comp_r[i];
    end
  end

endmodule

@@ hw/rtl/qmn_norm_cell.sv @@
// block scaling cell: shifts all four components left by SHIFT when all still fit
// depends on qmn_pkg
module qmn_norm_cell import qmn_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  qmn_norm_t cell_in,
  output qmn_norm_t cell_out
);

  qmn_norm_t cell_r;
  qmn_norm_t cell_nxt;

  always_comb begin
    logic             fits;
    logic [SHIFT:0]   top;
    fits = 1'b1;
    for (int i = 0; i < 4; i++) begin
      top = cell_in.comp[i][CW-1 -: SHIFT+1];
      if (!((top == '0) || (&top))) begin
        fits = 1'b0;
      end
    end
    cell_nxt = cell_in;
    for (int i = 0; i < 4; i++) begin
      if (fits) begin
        cell_nxt.comp[i] = cell_in.comp[i] << SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

@@ hw/rtl/qmn_sqrt_cell.sv @@
// one step of the digit-by-digit square root, two radicand bits per cell
// depends on qmn_pkg
module qmn_sqrt_cell import qmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  qmn_sqrt_t cell_in,
  output qmn_sqrt_t cell_out
);

  localparam int XW = RMW + 2;

  qmn_sqrt_t cell_r;
  qmn_sqrt_t cell_nxt;

  always_comb begin
    logic [XW-1:0] rem_sh;
    logic [XW-1:0] trial;
    logic [XW-1:0] diff;
    logic          ge;
    rem_sh = {cell_in.rem, cell_in.src[SRCW-1 -: 2]};
    trial  = {2'b00, cell_in.root, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    cell_nxt      = cell_in;
    cell_nxt.rem  = ge ? diff[RMW-1:0] : rem_sh[RMW-1:0];
    cell_nxt.root = {cell_in.root[RTW-2:0], ge};
    cell_nxt.src  = {cell_in.src[SRCW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

@@ hw/rtl/qmn_div_cell.sv @@
// one restoring division step for all four lanes, one quotient bit per cell
// depends on qmn_pkg
module qmn_div_cell import qmn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  qmn_div_t cell_in,
  output qmn_div_t cell_out
);

  qmn_div_t cell_r;
  qmn_div_t cell_nxt;

  always_comb begin
    logic [DW-1:0] r_sh;
    logic [DW-1:0] diff;
    logic          ge;
    cell_nxt = cell_in;
    for (int i = 0; i < 4; i++) begin
      r_sh = {cell_in.rem[i], cell_in.num[i][QW-1]};
      diff = r_sh - cell_in.den;
      ge   = (r_sh >= cell_in.den);
      cell_nxt.rem[i]  = ge ? diff[RTW-1:0] : r_sh[RTW-1:0];
      cell_nxt.quot[i] = {cell_in.quot[i][QW-2:0], ge};
      cell_nxt.num[i]  = {cell_in.num[i][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

@@ hw/rtl/quaternion_multiply_normalize.sv @@
// quaternion product renormalized to unit length, Q2.30 in and out
// stages in order: product, block scaling cells, squares, square root 32 cells,
// divide setup, divide 31 cells, output; one request per cycle unless stalled
// the whole chain halts together while a result waits under out_stall
// synchronous active-low reset clears the valid bit of every stage
module quaternion_multiply_normalize import qmn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qmn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qmn_out_t out_data
);

  logic      en;
  qmn_norm_t norm_link [NORM_STAGES+1];
  qmn_sqrt_t sqrt_link [SQRT_STEPS+1];
  qmn_div_t  div_link  [DIV_STEPS+1];

  logic signed [SQW-1:0] sq_r [4];
  logic [3:0][VW-1:0]    vec1_r;
  logic [3:0][VW-1:0]    vec2_r;
  logic                  zero1_r;
  logic                  zero2_r;
  logic                  valid1_r;
  logic                  valid2_r;
  logic [SW-1:0]         sum_r;
  logic [SW-1:0]         sum_nxt;
  qmn_div_t              prep_r;
  qmn_div_t              prep_nxt;
  logic                  out_valid_r;
  qmn_out_t              out_data_r;
  qmn_out_t              out_data_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign en       = ~in_stall;

  qmn_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cells_out (norm_link[0])
  );

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    qmn_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - g))) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (norm_link[g]),
      .cell_out (norm_link[g+1])
    );
  end

  // squares of the scaled components
  always_ff @(posedge clk) begin
    logic signed [VW-1:0] v;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        v         = norm_link[NORM_STAGES].comp[i][CW-1 -: VW];
        sq_r[i]   <= v * v;
        vec1_r[i] <= norm_link[NORM_STAGES].comp[i][CW-1 -: VW];
      end
      zero1_r <= norm_link[NORM_STAGES].zero;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sum_nxt = sum_nxt + {1'b0, sq_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      vec2_r  <= vec1_r;
      zero2_r <= zero1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= norm_link[NORM_STAGES].valid;
      valid2_r <= valid1_r;
    end
  end

  always_comb begin
    sqrt_link[0].valid = valid2_r;
    sqrt_link[0].zero  = zero2_r;
    sqrt_link[0].vec   = vec2_r;
    sqrt_link[0].rem   = '0;
    sqrt_link[0].root  = '0;
    sqrt_link[0].src   = {1'b0, sum_r};
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qmn_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (sqrt_link[g]),
      .cell_out (sqrt_link[g+1])
    );
  end

  // dividend (2 * |v| * 2^30 + n), divisor 2n
  always_comb begin
    logic [RTW-1:0]  n;
    logic [VW-1:0]   v;
    logic [VW-1:0]   mag;
    logic [2*QW-1:0] dvd;
    n = sqrt_link[SQRT_STEPS].root;
    prep_nxt.valid = sqrt_link[SQRT_STEPS].valid;
    prep_nxt.zero  = sqrt_link[SQRT_STEPS].zero;
    prep_nxt.den   = {n, 1'b0};
    for (int i = 0; i < 4; i++) begin
      v   = sqrt_link[SQRT_STEPS].vec[i];
      mag = v[VW-1] ? (~v + 1'b1) : v;
      dvd = {mag, {QW{1'b0}}} + {{(2*QW-RTW){1'b0}}, n};
      prep_nxt.neg[i]  = v[VW-1];
      prep_nxt.rem[i]  = {1'b0, dvd[2*QW-1 -: QW]};
      prep_nxt.num[i]  = dvd[QW-1:0];
      prep_nxt.quot[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign div_link[0] = prep_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    qmn_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (div_link[g]),
      .cell_out (div_link[g+1])
    );
  end

  always_comb begin
    logic [OW-1:0] q [4];
    for (int i = 0; i < 4; i++) begin
      q[i] = {1'b0, div_link[DIV_STEPS].quot[i]};
      if (div_link[DIV_STEPS].neg[i]) begin
        q[i] = ~q[i] + 1'b1;
      end
    end
    if (div_link[DIV_STEPS].zero) begin
      out_data_nxt.prod_w        = Q_ONE;
      out_data_nxt.prod_x        = '0;
      out_data_nxt.prod_y        = '0;
      out_data_nxt.prod_z        = '0;
      out_data_nxt.zero_fallback = 1'b1;
    end else begin
      out_data_nxt.prod_w        = q[0];
      out_data_nxt.prod_x        = q[1];
      out_data_nxt.prod_y        = q[2];
      out_data_nxt.prod_z        = q[3];
      out_data_nxt.zero_fallback = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_link[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/testbench.sv @@
// testbench for quaternion_multiply_normalize: directed table, then random requests
// checked against a local hamilton-product-and-normalize predictor; uses qmn_pkg
`timescale 1ns / 100ps

module testbench;
  import qmn_pkg::*;

  localparam int N_RANDOM    = 1950;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    qmn_in_t  req;
    bit       typed;
    qmn_out_t want;
  } table_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  qmn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qmn_out_t out_data;

  qmn_out_t   pending_q[$];
  int         errors = 0;
  int         cycles = 0;
  int         n_sent = 0;
  int         n_seen = 0;
  int         n_fallback = 0;
  bit         calm = 1'b0;
  table_row_t directed[$];

  quaternion_multiply_normalize i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic qmn_out_t unit_product(qmn_in_t q);
    logic signed [67:0]  a[4];
    logic signed [67:0]  b[4];
    logic signed [67:0]  c[4];
    logic signed [127:0] t;
    longint              v[4];
    longint unsigned     ssum, root, trial, mag, quo;
    bit                  fit;
    int                  k, i;
    qmn_out_t            r;
    a[0] = q.left_w;  a[1] = q.left_x;  a[2] = q.left_y;  a[3] = q.left_z;
    b[0] = q.right_w; b[1] = q.right_x; b[2] = q.right_y; b[3] = q.right_z;
    c[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    c[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    c[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    c[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    r = '0;
    if (c[0] == 0 && c[1] == 0 && c[2] == 0 && c[3] == 0) begin
      r.prod_w = Q_ONE;
      r.zero_fallback = 1'b1;
      return r;
    end
    // block scaling: largest shift that keeps every component in range
    for (k = 30; k >= -70; k--) begin
      fit = 1'b1;
      for (i = 0; i < 4; i++) begin
        t = c[i];
        if (k >= 0) t = t <<< k;
        else t = t >>> (-k);
        if (t < -128'sd1073741824 || t >= 128'sd1073741824) fit = 1'b0;
        v[i] = longint'(t);
      end
      if (fit) break;
    end
    ssum = 0;
    for (i = 0; i < 4; i++) ssum += longint'(v[i] * v[i]);
    root = 0;
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= ssum) root = trial;
    end
    if (root == 0) root = 1;
    for (i = 0; i < 4; i++) begin
      mag = (v[i] < 0 ? -v[i] : v[i]);
      mag = mag << 30;
      quo = (2 * mag + root) / (2 * root);
      t = (v[i] < 0) ? -$signed({64'd0, quo}) : $signed({64'd0, quo});
      case (i)
        0: r.prod_w = t[31:0];
        1: r.prod_x = t[31:0];
        2: r.prod_y = t[31:0];
        default: r.prod_z = t[31:0];
      endcase
    end
    return r;
  endfunction

  function automatic qmn_in_t mk(int lw, int lx, int ly, int lz,
                                 int rw, int rx, int ry, int rz);
    qmn_in_t q;
    q.left_w = lw;  q.left_x = lx;  q.left_y = ly;  q.left_z = lz;
    q.right_w = rw; q.right_x = rx; q.right_y = ry; q.right_z = rz;
    return q;
  endfunction

  function automatic qmn_out_t unit(int w, int x, int y, int z, bit fb);
    qmn_out_t o;
    o.prod_w = w; o.prod_x = x; o.prod_y = y; o.prod_z = z;
    o.zero_fallback = fb;
    return o;
  endfunction

  function automatic logic signed [31:0] rand_comp(int mode);
    logic signed [31:0] r;
    case (mode)
      0: r = $urandom;
      1: r = $signed($urandom_range(0, 32'h0000_0fff)) - 2048;
      2: r = $signed($urandom_range(0, 8)) - 4;
      3: r = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
      default: r = ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
    return r;
  endfunction

  task automatic send(qmn_in_t q, bit typed, qmn_out_t want);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = q;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? want : unit_product(q));
    n_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  always @(posedge clk) begin
    qmn_out_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycles, pending_q.size());
      $display("testbench: done, errors");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (out_data.zero_fallback) n_fallback++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want w=%h x=%h y=%h z=%h f=%b got w=%h x=%h y=%h z=%h f=%b",
                     want.prod_w, want.prod_x, want.prod_y, want.prod_z, want.zero_fallback,
                     out_data.prod_w, out_data.prod_x, out_data.prod_y, out_data.prod_z,
                     out_data.zero_fallback);
        end
      end
    end
  end

  initial begin
    qmn_in_t q;
    int      i, mode, guard;
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, unit(32'h4000_0000, 0, 0, 0, 1)});
    directed.push_back('{mk(0, 0, 0, 0, -1, 32'h7fffffff, 5, -9), 1,
                         unit(32'h4000_0000, 0, 0, 0, 1)});
    directed.push_back('{mk(32'h1234567, -3, 77, 32'h80000000, 0, 0, 0, 0), 1,
                         unit(32'h4000_0000, 0, 0, 0, 1)});
    directed.push_back('{mk(32'h40000000, 0, 0, 0, 32'h40000000, 0, 0, 0), 1,
                         unit(32'h4000_0000, 0, 0, 0, 0)});
    directed.push_back('{mk(0, 32'h40000000, 0, 0, 0, 0, 32'h40000000, 0), 1,
                         unit(0, 0, 0, 32'h4000_0000, 0)});
    directed.push_back('{mk(0, 0, 32'h40000000, 0, 0, 0, 0, 32'h40000000), 1,
                         unit(0, 32'h4000_0000, 0, 0, 0)});
    directed.push_back('{mk(0, 32'h40000000, 0, 0, 0, 32'h40000000, 0, 0), 1,
                         unit(32'hc000_0000, 0, 0, 0, 0)});
    directed.push_back('{mk(1, 0, 0, 0, 1, 0, 0, 0), 1, unit(32'h4000_0000, 0, 0, 0, 0)});
    directed.push_back('{mk(-1, 0, 0, 0, 1, 0, 0, 0), 1, unit(32'hc000_0000, 0, 0, 0, 0)});
    directed.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000), 0, '0});
    directed.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, '0});
    directed.push_back('{mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000), 0, '0});
    directed.push_back('{mk(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0), 1,
                         unit(32'h4000_0000, 0, 0, 0, 0)});
    directed.push_back('{mk(1, 1, 1, 1, 1, -1, -1, -1), 0, '0});
    directed.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1), 0, '0});
    directed.push_back('{mk(3, 0, 0, 0, 0, 1, 1, 0), 0, '0});
    directed.push_back('{mk(32'h2d413ccd, 32'h2d413ccd, 0, 0, 32'h2d413ccd, 0, 0,
                            32'h2d413ccd), 0, '0});
    directed.push_back('{mk(32'hffffffff, 32'h7fffffff, 1, 32'h80000000,
                            32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0), 0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].want);
    for (i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 800 && i < 1100);
      mode = $urandom_range(0, 9);
      if (mode < 5) mode = 0;
      else if (mode < 7) mode = 1;
      else if (mode < 8) mode = 2;
      else if (mode < 9) mode = 3;
      else mode = 4;
      q = mk(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
             rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
      if ($urandom_range(0, 29) == 0) begin
        if ($urandom_range(0, 1)) q[255:128] = '0;
        else q[127:0] = '0;
      end
      send(q, 1'b0, '0);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    guard = 0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
    if (pending_q.size() != 0) begin
      errors += pending_q.size();
      $display("%0d results never arrived", pending_q.size());
    end
    $display("sent %0d quaternion pairs (%0d directed), checked %0d results",
             n_sent, directed.size(), n_seen);
    $display("%0d zero-product fallbacks seen, %0d mismatches", n_fallback, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/qmn_pkg.sv
hw/rtl/qmn_prod.sv
hw/rtl/qmn_norm_cell.sv
hw/rtl/qmn_sqrt_cell.sv
hw/rtl/qmn_div_cell.sv
hw/rtl/quaternion_multiply_normalize.sv
sim/testbench.sv
